[design/suidset_pkg.sv]
// ----------------------------------------------------------------------------
// suidset_pkg
// Shared types, constants and controller/datapath interface structs for the
// sorted unique id set with FNV-1a 64 hash.
// ----------------------------------------------------------------------------
package suidset_pkg;

  // Table geometry
  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths
  localparam int ID_W     = 64;
  localparam int RIDX_W   = 8;
  localparam int COUNT_W  = 9;
  localparam int MAXE_W   = 9;
  localparam int STATUS_W = 3;

  localparam logic [MAXE_W-1:0] MAX_ENTRIES_RST = MAXE_W'(256);

  // FNV-1a 64: prime = 2^40 + 0x1B3
  localparam logic [63:0] FNV_BASIS    = 64'hCBF2_9CE4_8422_2325;
  localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;
  localparam int          FNV_PRIME_SH = 40;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REPORT = 2'd1,
    REQ_READ   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_DUP      = 3'd1,
    ST_IGNORED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_OK       = 3'd4,
    ST_BADIDX   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    RD_IDX   = 2'd0,
    RD_IDXM1 = 2'd1,
    RD_RIDX  = 2'd2
  } rd_sel_t;

  typedef enum logic [2:0] {
    IDX_HOLD = 3'd0,
    IDX_ZERO = 3'd1,
    IDX_HELD = 3'd2,
    IDX_INC  = 3'd3,
    IDX_DEC  = 3'd4
  } idx_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DECIDE,
    S_SHIFT_CHK,
    S_SHIFT_WR,
    S_HASH_RD,
    S_HASH_LD,
    S_HASH_BYTE,
    S_READ_WAIT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic    load_req;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    logic    wr_id;      // 1: write the request id, 0: write read data (shift)
    idx_op_t idx_op;
    logic    pos_save;
    logic    held_inc;
    logic    held_clr;
    logic    st_load;
    status_t st_code;
    logic    entry_load;
    logic    hash_init;
    logic    word_load;
    logic    hash_step;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    req_t req;
    logic ignored;
    logic idx_eq_held;
    logic idx_eq_pos;
    logic rd_lt_id;
    logic rd_eq_id;
    logic full;
    logic ridx_ok;
    logic byte_last;
  } dp_sts_t;

endpackage

[design/suidset_dp.sv]
// ----------------------------------------------------------------------------
// suidset_dp
// Datapath: id table memory, count, pointers, hash unit and result registers.
// ----------------------------------------------------------------------------
module suidset_dp
  import suidset_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic [1:0]          req_type,
  input  logic [ID_W-1:0]     item_id,
  input  logic                qualifies,
  input  logic [RIDX_W-1:0]   read_index,
  input  logic                cfg_we,
  input  logic [MAXE_W-1:0]   cfg_data,
  output logic [STATUS_W-1:0] status,
  output logic [COUNT_W-1:0]  count_out,
  output logic [ID_W-1:0]     hash_out,
  output logic [ID_W-1:0]     entry_value
);

  logic [ID_W-1:0]   mem [CAPACITY];

  req_t              req;
  logic [ID_W-1:0]   id;
  logic              qual;
  logic [RIDX_W-1:0] rindex;
  logic [MAXE_W-1:0] max_entries;
  logic [CNT_W-1:0]  held;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  pos;
  logic [ID_W-1:0]   rdata;
  logic [ID_W-1:0]   word;
  logic [2:0]        bcnt;
  logic [63:0]       hash;
  status_t           st;
  logic [ID_W-1:0]   entry;

  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  idx_m1;
  logic [63:0]       hx;
  logic [63:0]       hash_next;

  assign idx_m1 = idx - CNT_W'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_IDX:   rd_addr = idx[ADDR_W-1:0];
      RD_IDXM1: rd_addr = idx_m1[ADDR_W-1:0];
      RD_RIDX:  rd_addr = ADDR_W'(rindex);
      default:  rd_addr = idx[ADDR_W-1:0];
    endcase
  end

  // One FNV-1a byte: xor the low byte, multiply by 2^40 + 0x1B3
  assign hx        = hash ^ {56'd0, word[7:0]};
  assign hash_next = (hx * 64'(FNV_PRIME_LO)) + {hx[63-FNV_PRIME_SH:0], FNV_PRIME_SH'(0)};

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[idx[ADDR_W-1:0]] <= cmd.wr_id ? id : rdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Control-type state
  always_ff @(posedge clk) begin
    if (rst) begin
      held        <= '0;
      max_entries <= MAX_ENTRIES_RST;
    end else begin
      if (cfg_we) begin
        max_entries <= cfg_data;
      end
      if (cmd.held_clr) begin
        held <= '0;
      end else if (cmd.held_inc) begin
        held <= held + CNT_W'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req    <= req_t'(req_type);
      id     <= item_id;
      qual   <= qualifies;
      rindex <= read_index;
    end
    case (cmd.idx_op)
      IDX_ZERO: idx <= '0;
      IDX_HELD: idx <= held;
      IDX_INC:  idx <= idx + CNT_W'(1);
      IDX_DEC:  idx <= idx_m1;
      default:  idx <= idx;
    endcase
    if (cmd.pos_save) begin
      pos <= idx;
    end
    if (cmd.st_load) begin
      st <= cmd.st_code;
    end
    if (cmd.entry_load) begin
      entry <= rdata;
    end
    if (cmd.hash_init) begin
      hash <= FNV_BASIS;
    end else if (cmd.hash_step) begin
      hash <= hash_next;
    end
    if (cmd.word_load) begin
      word <= rdata;
      bcnt <= '0;
    end else if (cmd.hash_step) begin
      word <= {8'd0, word[ID_W-1:8]};
      bcnt <= bcnt + 3'd1;
    end
    if (cmd.out_load) begin
      status      <= st;
      count_out   <= COUNT_W'(held);
      hash_out    <= (req == REQ_REPORT) ? hash : '0;
      entry_value <= (req == REQ_READ && st == ST_OK) ? entry : '0;
    end
  end

  always_comb begin
    sts.req         = req;
    sts.ignored     = (id == '0) || !qual;
    sts.idx_eq_held = (idx == held);
    sts.idx_eq_pos  = (idx == pos);
    sts.rd_lt_id    = (rdata < id);
    sts.rd_eq_id    = (rdata == id);
    sts.full        = (CNT_W'(max_entries) <= held) || (held >= CNT_W'(CAPACITY))
                      || (max_entries == '0);
    sts.ridx_ok     = (CNT_W'(rindex) < held);
    sts.byte_last   = (bcnt == 3'd7);
  end

endmodule

[design/suidset_ctrl.sv]
// ----------------------------------------------------------------------------
// suidset_ctrl
// Request sequencer: scan, shift-insert, hash walk, entry read and clear.
// ----------------------------------------------------------------------------
module suidset_ctrl
  import suidset_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (sts.req)
          REQ_ADD:    state_next = sts.ignored ? S_FIN : S_SCAN_RD;
          REQ_REPORT: state_next = S_HASH_RD;
          REQ_READ:   state_next = sts.ridx_ok ? S_READ_WAIT : S_FIN;
          default:    state_next = S_FIN;
        endcase
      end
      S_SCAN_RD: begin
        state_next = sts.idx_eq_held ? S_DECIDE : S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (sts.rd_lt_id)      state_next = S_SCAN_RD;
        else if (sts.rd_eq_id) state_next = S_FIN;
        else                   state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = sts.full ? S_FIN : S_SHIFT_CHK;
      end
      S_SHIFT_CHK: begin
        state_next = sts.idx_eq_pos ? S_FIN : S_SHIFT_WR;
      end
      S_SHIFT_WR:  state_next = S_SHIFT_CHK;
      S_HASH_RD: begin
        state_next = sts.idx_eq_held ? S_FIN : S_HASH_LD;
      end
      S_HASH_LD:   state_next = S_HASH_BYTE;
      S_HASH_BYTE: begin
        if (sts.byte_last) state_next = S_HASH_RD;
      end
      S_READ_WAIT: state_next = S_FIN;
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default:     state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = RD_IDX;
    cmd.idx_op     = IDX_HOLD;
    cmd.st_code    = ST_OK;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      S_DISPATCH: begin
        case (sts.req)
          REQ_ADD: begin
            cmd.idx_op  = IDX_ZERO;
            cmd.st_load = sts.ignored;
            cmd.st_code = ST_IGNORED;
          end
          REQ_REPORT: begin
            cmd.idx_op    = IDX_ZERO;
            cmd.hash_init = 1'b1;
            cmd.st_load   = 1'b1;
            cmd.st_code   = ST_OK;
          end
          REQ_READ: begin
            cmd.rd_en   = sts.ridx_ok;
            cmd.rd_sel  = RD_RIDX;
            cmd.st_load = 1'b1;
            cmd.st_code = sts.ridx_ok ? ST_OK : ST_BADIDX;
          end
          default: begin
            cmd.held_clr = 1'b1;
            cmd.st_load  = 1'b1;
            cmd.st_code  = ST_OK;
          end
        endcase
      end
      S_SCAN_RD: begin
        cmd.rd_en = !sts.idx_eq_held;
      end
      S_SCAN_CMP: begin
        if (sts.rd_lt_id) begin
          cmd.idx_op = IDX_INC;
        end else if (sts.rd_eq_id) begin
          cmd.st_load = 1'b1;
          cmd.st_code = ST_DUP;
        end
      end
      S_DECIDE: begin
        cmd.pos_save = 1'b1;
        cmd.idx_op   = IDX_HELD;
        cmd.st_load  = sts.full;
        cmd.st_code  = ST_FULL;
      end
      S_SHIFT_CHK: begin
        if (sts.idx_eq_pos) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_id    = 1'b1;
          cmd.held_inc = 1'b1;
          cmd.st_load  = 1'b1;
          cmd.st_code  = ST_INSERTED;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDXM1;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.idx_op = IDX_DEC;
      end
      S_HASH_RD: begin
        cmd.rd_en = !sts.idx_eq_held;
      end
      S_HASH_LD: begin
        cmd.word_load = 1'b1;
      end
      S_HASH_BYTE: begin
        cmd.hash_step = 1'b1;
        if (sts.byte_last) cmd.idx_op = IDX_INC;
      end
      S_READ_WAIT: begin
        cmd.entry_load = 1'b1;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[design/sorted_unique_id_set_with_hash_core.sv]
// ----------------------------------------------------------------------------
// sorted_unique_id_set_with_hash_core
// Ascending duplicate-free table of 64-bit ids with count, indexed read,
// clear, and an FNV-1a 64 hash over the held ids.
// ----------------------------------------------------------------------------
// One request is in flight at a time; the core takes a new request only once the
// last result has been loaded into the output registers. Add scans for the insert
// position and shifts entries up through the single-port table; report walks the
// held ids with a read, a load and eight byte steps per id in the byte-serial hash.
// Reset (rst, synchronous, high) empties the table, sets max_entries to 256.
// ----------------------------------------------------------------------------
module sorted_unique_id_set_with_hash_core
  import suidset_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          req_type,
  input  logic [ID_W-1:0]     item_id,
  input  logic                qualifies,
  input  logic [RIDX_W-1:0]   read_index,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [COUNT_W-1:0]  count_out,
  output logic [ID_W-1:0]     hash_out,
  output logic [ID_W-1:0]     entry_value,
  // max_entries write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [MAXE_W-1:0]   cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The user must write the limit register only while idle; the block does not enforce it, so take every transfer.
  assign cfg_ready = 1'b1;

  // Sequencer: walks the table for each request and hands the datapath one
  // command word per cycle. A finished result sits in the output registers
  // while the next request is taken; the sequencer holds in its final state
  // only if that earlier result has not been transferred yet.
  suidset_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: the id memory (one write, one registered read per cycle), the
  // held count, scan/shift pointers, the byte-serial hash and result registers.
  // Insertion scans upward for the sorted position, then shifts entries up one
  // slot at a time from the top before writing the new id.
  suidset_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (req_type),
    .item_id     (item_id),
    .qualifies   (qualifies),
    .read_index  (read_index),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .status      (status),
    .count_out   (count_out),
    .hash_out    (hash_out),
    .entry_value (entry_value)
  );

endmodule

[design/suidset_chk.sv]
// ----------------------------------------------------------------------------
// suidset_chk
// Port-level checks on the result channel of the id set core.
// ----------------------------------------------------------------------------
module suidset_chk
  import suidset_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [COUNT_W-1:0]  count_out,
  input logic [ID_W-1:0]     hash_out,
  input logic [ID_W-1:0]     entry_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count_out))
    else $error("result changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> count_out <= COUNT_W'(CAPACITY))
    else $error("count beyond capacity");

  a_entry_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> entry_value == '0)
    else $error("entry value on a non-ok result");

  a_hash_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_INSERTED || status == ST_DUP || status == ST_FULL
                  || status == ST_IGNORED || status == ST_BADIDX) |-> hash_out == '0)
    else $error("hash on a non-report result");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_INSERTED) |-> count_out != '0)
    else $error("insert reported with empty table");

endmodule

bind sorted_unique_id_set_with_hash_core suidset_chk u_suidset_chk (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .count_out   (count_out),
  .hash_out    (hash_out),
  .entry_value (entry_value)
);
